// File: design/lkv_pkg.sv
package lkv_pkg;

    localparam int LKV_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int VALUE_W     = 32;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE,
        ST_DONE
    } lkv_state_t;

    typedef struct packed {
        logic load_in;
        logic do_match;
        logic do_update;
        logic load_out;
    } lkv_cmd_t;

endpackage

// File: design/lkv_ctrl.sv
module lkv_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output lkv_pkg::lkv_cmd_t cmd
);
    import lkv_pkg::*;

    lkv_state_t state_reg;
    lkv_state_t state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       can_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign can_load = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MATCH;
                end
            end
            ST_MATCH: begin
                cmd.do_match = 1'b1;
                state_next   = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.do_update = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (can_load) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    s_ready      = 1'b1;
                    if (s_valid) begin
                        cmd.load_in = 1'b1;
                        state_next  = ST_MATCH;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/lkv_datapath.sv
module lkv_datapath #(
    parameter int ENTRIES = lkv_pkg::LKV_ENTRIES
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lkv_pkg::lkv_cmd_t          cmd,
    input  logic                       s_operation,
    input  logic [lkv_pkg::KEY_W-1:0]   s_key,
    input  logic [lkv_pkg::VALUE_W-1:0] s_value,
    output logic                       m_hit,
    output logic [lkv_pkg::VALUE_W-1:0] m_data,
    output logic                       m_evicted
);
    import lkv_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    // item registers
    logic               op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;

    // entry cells
    logic [ENTRIES-1:0] valid_reg;
    logic [KEY_W-1:0]   entry_key_reg [ENTRIES];
    logic [IDX_W-1:0]   rank_reg      [ENTRIES];
    logic [VALUE_W-1:0] value_mem     [ENTRIES];

    // compare stage results
    logic [ENTRIES-1:0] match_reg;
    logic [ENTRIES-1:0] lru_reg;
    logic [ENTRIES-1:0] free_first_reg;
    logic               hit_reg;
    logic               full_reg;
    logic [IDX_W-1:0]   hit_rank_reg;
    logic [VALUE_W-1:0] rd_data_reg;

    logic               m_hit_reg;
    logic [VALUE_W-1:0] m_data_reg;
    logic               m_evicted_reg;

    logic [ENTRIES-1:0] match_v;
    logic [ENTRIES-1:0] lru_v;
    logic [ENTRIES-1:0] free_v;
    logic [IDX_W-1:0]   hit_rank_v;

    logic               is_insert;
    logic               new_ins;
    logic [ENTRIES-1:0] sel_v;
    logic [IDX_W-1:0]   sel_idx;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg    <= s_operation;
            key_reg   <= s_key;
            value_reg <= s_value;
        end
    end

    always_comb begin
        hit_rank_v = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match_v[i] = valid_reg[i] && (entry_key_reg[i] == key_reg);
            lru_v[i]   = valid_reg[i] && (rank_reg[i] == IDX_W'(ENTRIES - 1));
            if (match_v[i]) begin
                hit_rank_v = hit_rank_v | rank_reg[i];
            end
        end
        free_v = ~valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_match) begin
            match_reg      <= match_v;
            lru_reg        <= lru_v;
            free_first_reg <= free_v & (~free_v + ENTRIES'(1));
            hit_reg        <= |match_v;
            full_reg       <= &valid_reg;
            hit_rank_reg   <= hit_rank_v;
        end
    end

    assign is_insert = (op_reg == OP_INSERT);
    assign new_ins   = is_insert && !hit_reg;

    always_comb begin
        if (hit_reg) begin
            sel_v = match_reg;
        end else if (new_ins) begin
            sel_v = full_reg ? lru_reg : free_first_reg;
        end else begin
            sel_v = '0;
        end
        sel_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (sel_v[i]) begin
                sel_idx = sel_idx | IDX_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.do_update && new_ins) begin
            valid_reg <= valid_reg | sel_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_update) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (sel_v[i]) begin
                    rank_reg[i] <= '0;
                    if (is_insert) begin
                        entry_key_reg[i] <= key_reg;
                    end
                end else if (valid_reg[i] &&
                             (new_ins || (hit_reg && rank_reg[i] < hit_rank_reg))) begin
                    rank_reg[i] <= rank_reg[i] + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_update) begin
            if (is_insert && (hit_reg || new_ins)) begin
                value_mem[sel_idx] <= value_reg;
            end
            rd_data_reg <= value_mem[sel_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_hit_reg     <= hit_reg;
            m_data_reg    <= (!is_insert && hit_reg) ? rd_data_reg : '0;
            m_evicted_reg <= new_ins && full_reg;
        end
    end

    assign m_hit     = m_hit_reg;
    assign m_data    = m_data_reg;
    assign m_evicted = m_evicted_reg;

endmodule

// File: design/lru_key_value_cache_unit.sv
// channel | ports                                  | direction
// input   | s_valid s_ready s_operation s_key s_value | in
// result  | m_valid m_ready m_hit m_data m_evicted     | out
//
// Per item: key compare over all entries, rank and slot update
// with value memory access, then a step that loads the result register and
// takes the next beat; no new beat is taken before that last step.
// A stalled result holds the block in its last step until m_ready frees it.
// Reset clears the valid bits and the control state; no clearing pass.
module lru_key_value_cache_unit #(
    parameter int ENTRIES = lkv_pkg::LKV_ENTRIES
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_operation,
    input  logic [lkv_pkg::KEY_W-1:0]   s_key,
    input  logic [lkv_pkg::VALUE_W-1:0] s_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_hit,
    output logic [lkv_pkg::VALUE_W-1:0] m_data,
    output logic                       m_evicted
);
    import lkv_pkg::*;

    lkv_cmd_t cmd;

    lkv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    lkv_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_operation (s_operation),
        .s_key       (s_key),
        .s_value     (s_value),
        .m_hit       (m_hit),
        .m_data      (m_data),
        .m_evicted   (m_evicted)
    );

endmodule

// File: design/lkv_checker.sv
module lkv_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_hit,
    input logic [lkv_pkg::VALUE_W-1:0] m_data,
    input logic                       m_evicted
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_data)
            && $stable(m_evicted))
        else $error("stalled result beat changed");

    a_evict_not_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && m_evicted))
        else $error("eviction reported on a hit");

    a_evict_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_evicted |-> m_data == '0)
        else $error("insert result carries data");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("beat taken while compare in progress");

endmodule

bind lru_key_value_cache_unit lkv_checker u_lkv_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_hit     (m_hit),
    .m_data    (m_data),
    .m_evicted (m_evicted)
);
